// ----- rtl/tiks_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiks_pkg
// Shared types and constants of the key search over a byte-coded index.
// ----------------------------------------------------------------------------
package tiks_pkg;

    localparam int MEM_DEPTH  = 4096;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int PTR_W      = ADDR_W + 1;
    localparam int MAX_GROUPS = 10;
    localparam int CNT_W      = $clog2(MAX_GROUPS + 1);
    localparam int KEY_W      = 32;
    localparam int NUM_W      = 64;
    localparam int SH_W       = $clog2(NUM_W);

    localparam logic       CMD_WRITE  = 1'b0;
    localparam logic       CMD_SEARCH = 1'b1;

    localparam logic       CFG_FLAG_BITS = 1'b0;
    localparam logic       CFG_FLAG_MASK = 1'b1;

    localparam logic [3:0] FLAG_BITS_RST = 4'd2;
    localparam logic [7:0] FLAG_MASK_RST = 8'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_BACK_VAL,
        ST_BACK_KEY,
        ST_DECODE,
        ST_SHIFT,
        ST_COMPARE,
        ST_SKIP,
        ST_FINISH
    } t_state;

endpackage

// ----- rtl/tight_index_key_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tight_index_key_search
// Binary search for a key in a byte-coded key/value index held in memory.
// ----------------------------------------------------------------------------
// A write transaction stores one index byte and returns nothing; a search
// transaction returns exactly one result. A search walks the index through
// the single read port of the index memory, one byte per cycle. Each probe
// checks the range, backs over value bytes and then key bytes, decodes the
// key, shifts off the flag bits and compares; when it moves to the upper
// half it also skips value bytes. A search ends on a match, a failed range
// check or a skip that reaches the upper bound, and hands its result to the
// output register once that register is free. Over a 4096-byte index of
// short entries a search makes about twelve or thirteen probes, more when
// long runs of key bytes keep the range from halving. The input is not
// ready while a search runs or while reset is applied; a finished result
// waits in an output register while the next transaction is taken.
module tight_index_key_search
    import tiks_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // write_addr[11:0], write_byte[19:12], search_key[51:20],
    // range_start[64:52], range_stop[77:65], zero fill above.
    input  logic [79:0] s_axis_tdata,
    // cmd[0].
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // entry_flags[7:0], value_pos[20:8], zero fill above.
    output logic [23:0] m_axis_tdata,
    // found[0].
    output logic        m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);

    t_state             r_state, n_state;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [PTR_W-1:0]   r_lo, n_lo;
    logic [PTR_W-1:0]   r_hi, n_hi;
    logic [PTR_W-1:0]   r_p, n_p;
    logic [PTR_W-1:0]   r_start, n_start;
    logic               r_cls, n_cls;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [NUM_W-1:0]   r_acc, n_acc;
    logic [7:0]         r_flags, n_flags;
    logic               r_hit, n_hit;
    logic [3:0]         r_flag_bits;
    logic [7:0]         r_flag_mask;
    logic [7:0]         r_byte;
    logic [7:0]         r_mem [MEM_DEPTH];

    logic               r_o_valid, n_o_valid;
    logic               r_o_found, n_o_found;
    logic [7:0]         r_o_flags, n_o_flags;
    logic [PTR_W-1:0]   r_o_pos, n_o_pos;

    logic [ADDR_W-1:0]  w_wr_addr;
    logic [7:0]         w_wr_byte;
    logic [KEY_W-1:0]   w_in_key;
    logic [PTR_W-1:0]   w_in_start, w_in_stop;
    logic [PTR_W-1:0]   w_span, w_mid;
    logic               w_in_acc, w_can, w_p_gt_lo, w_p_lt_hi, w_dec_go;
    logic               w_eq, w_gt, w_out_free;
    logic [SH_W-1:0]    w_sh;
    logic [NUM_W-1:0]   w_key_ext;

    assign w_wr_addr  = s_axis_tdata[11:0];
    assign w_wr_byte  = s_axis_tdata[19:12];
    assign w_in_key   = s_axis_tdata[51:20];
    assign w_in_start = s_axis_tdata[64:52];
    assign w_in_stop  = s_axis_tdata[77:65];

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_span     = r_hi - r_lo;
    assign w_can      = (r_hi > r_lo) && (w_span > PTR_W'(1));
    assign w_mid      = r_lo + (w_span >> 1);
    assign w_p_gt_lo  = r_p > r_lo;
    assign w_p_lt_hi  = r_p < r_hi;
    assign w_dec_go   = (r_n < CNT_W'(MAX_GROUPS)) && w_p_lt_hi
                        && ((r_n == '0) || (r_byte[7] == r_cls));
    assign w_sh       = SH_W'(r_n) * SH_W'(7);
    assign w_key_ext  = NUM_W'(r_key);
    assign w_eq       = r_acc == w_key_ext;
    assign w_gt       = r_acc > w_key_ext;
    assign w_out_free = !r_o_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (s_axis_tuser == CMD_SEARCH)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = w_can ? ST_BACK_VAL : ST_FINISH;
            end
            ST_BACK_VAL: begin
                if (!(w_p_gt_lo && r_byte[7])) begin
                    n_state = ST_BACK_KEY;
                end
            end
            ST_BACK_KEY: begin
                if (!(w_p_gt_lo && !r_byte[7])) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!w_dec_go) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                n_state = ST_COMPARE;
            end
            ST_COMPARE: begin
                if (w_eq) begin
                    n_state = ST_FINISH;
                end else if (w_gt) begin
                    n_state = ST_CHECK;
                end else begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (!(w_p_lt_hi && r_byte[7])) begin
                    n_state = w_p_lt_hi ? ST_CHECK : ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_key     = r_key;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_p       = r_p;
        n_start   = r_start;
        n_cls     = r_cls;
        n_n       = r_n;
        n_acc     = r_acc;
        n_flags   = r_flags;
        n_hit     = r_hit;
        n_o_valid = r_o_valid && !m_axis_tready;
        n_o_found = r_o_found;
        n_o_flags = r_o_flags;
        n_o_pos   = r_o_pos;
        s_axis_tready = i_rst_n && (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (s_axis_tuser == CMD_SEARCH)) begin
                    n_key = w_in_key;
                    n_lo  = (w_in_start > PTR_W'(MEM_DEPTH)) ? PTR_W'(MEM_DEPTH) : w_in_start;
                    n_hi  = (w_in_stop > PTR_W'(MEM_DEPTH)) ? PTR_W'(MEM_DEPTH) : w_in_stop;
                    n_hit = 1'b0;
                end
            end
            ST_CHECK: begin
                if (w_can) begin
                    n_p = w_mid;
                end
            end
            ST_BACK_VAL: begin
                if (w_p_gt_lo && r_byte[7]) begin
                    n_p = r_p - PTR_W'(1);
                end
            end
            ST_BACK_KEY: begin
                if (w_p_gt_lo && !r_byte[7]) begin
                    n_p = r_p - PTR_W'(1);
                end else begin
                    n_p     = r_byte[7] ? r_p + PTR_W'(1) : r_p;
                    n_start = n_p;
                    n_n     = '0;
                    n_acc   = '0;
                end
            end
            ST_DECODE: begin
                if (w_dec_go) begin
                    if (r_n == '0) begin
                        n_cls = r_byte[7];
                    end
                    n_acc = r_acc | (NUM_W'(r_byte[6:0]) << w_sh);
                    n_n   = r_n + CNT_W'(1);
                    n_p   = r_p + PTR_W'(1);
                end
            end
            ST_SHIFT: begin
                n_acc   = r_acc >> r_flag_bits;
                n_flags = r_acc[7:0] & r_flag_mask;
            end
            ST_COMPARE: begin
                if (w_eq) begin
                    n_hit = 1'b1;
                end else if (w_gt) begin
                    n_hi = r_start;
                end
            end
            ST_SKIP: begin
                if (w_p_lt_hi && r_byte[7]) begin
                    n_p = r_p + PTR_W'(1);
                end else if (w_p_lt_hi) begin
                    n_lo = r_p;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_o_valid = 1'b1;
                    n_o_found = r_hit;
                    n_o_flags = r_hit ? r_flags : 8'd0;
                    n_o_pos   = r_hit ? r_p : '0;
                end
            end
            default: begin
                n_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_o_valid   <= 1'b0;
            r_flag_bits <= FLAG_BITS_RST;
            r_flag_mask <= FLAG_MASK_RST;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_FLAG_BITS: r_flag_bits <= i_cfg_wdata[3:0];
                    CFG_FLAG_MASK: r_flag_mask <= i_cfg_wdata;
                    default:       r_flag_mask <= r_flag_mask;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_p       <= n_p;
        r_start   <= n_start;
        r_cls     <= n_cls;
        r_n       <= n_n;
        r_acc     <= n_acc;
        r_flags   <= n_flags;
        r_hit     <= n_hit;
        r_o_found <= n_o_found;
        r_o_flags <= n_o_flags;
        r_o_pos   <= n_o_pos;
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (s_axis_tuser == CMD_WRITE)) begin
            r_mem[w_wr_addr] <= w_wr_byte;
        end
        r_byte <= r_mem[n_p[ADDR_W-1:0]];
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_found;
    assign m_axis_tdata  = {3'b000, r_o_pos, r_o_flags};

endmodule
